[rtl/urf_pkg.sv]
// Package for the ultrasonic range finder: phase codes, register indexes and the
// fixed-point constants of the timeout and distance scaling. Depends on nothing.
package urf_pkg;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_SETTLE    = 3'd1,
		PH_PULSE     = 3'd2,
		PH_WAIT_RISE = 3'd3,
		PH_MEASURE   = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		REG_MAX_RANGE   = 2'd0,
		REG_ECHO_POL    = 2'd1,
		REG_TRIGGER_POL = 2'd2
	} reg_index_t;

	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = 9;
	localparam int unsigned RANGE_W     = 9;
	localparam int unsigned DIST_W      = 11;

	// Echo timeout in ticks: floor(min(range, 400) * 14.55) + 10.
	// 14.55 is carried as 953549 / 2^16; the excess stays far below the 0.05 step of
	// the fractional parts over the whole range, so the floor comes out exact.
	localparam int unsigned RANGE_CAP_CM  = 400;
	localparam int unsigned LIMIT_MUL     = 953549;
	localparam int unsigned LIMIT_MUL_W   = 20;
	localparam int unsigned LIMIT_SHIFT   = 16;
	localparam int unsigned LIMIT_OFFSET  = 10;
	localparam int unsigned LIMIT_W       = 13;
	localparam int unsigned LIMIT_RESET   = RANGE_CAP_CM * 1455 / 100 + LIMIT_OFFSET;

	// Distance in sixteenths of a cm: (width * 18017 + 2^15) >> 16, i.e. width * 16 / 58.2.
	localparam int unsigned DIST_MUL   = 18017;
	localparam int unsigned DIST_MUL_W = 15;
	localparam int unsigned DIST_SHIFT = 16;
	localparam int unsigned DIST_ROUND = 1 << (DIST_SHIFT - 1);

endpackage

[rtl/urf_in_if.sv]
// Input channel of the ultrasonic range finder: one beat per microsecond tick,
// carrying the start command and the sampled echo level. No dependencies.
interface urf_in_if;
	logic valid;
	logic ready;
	logic operation;
	logic echo_level;

	modport source (output valid, output operation, output echo_level, input ready);
	modport sink (input valid, input operation, input echo_level, output ready);
endinterface

[rtl/urf_out_if.sv]
// Result channel of the ultrasonic range finder: one beat per tick with the trigger
// level, status flags and distance. Uses urf_pkg for the distance width.
interface urf_out_if;
	logic                         valid;
	logic                         ready;
	logic                         trigger_level;
	logic                         busy_res;
	logic                         done_res;
	logic                         timed_out;
	logic [urf_pkg::DIST_W-1:0]   distance_q4;

	modport source (
		output valid, output trigger_level, output busy_res, output done_res,
		output timed_out, output distance_q4, input ready
	);
	modport sink (
		input valid, input trigger_level, input busy_res, input done_res,
		input timed_out, input distance_q4, output ready
	);
endinterface

[rtl/ultrasonic_range_finder.sv]
// Ultrasonic range finder top level: trigger sequencing, echo timing and distance scaling.
// Depends on urf_pkg, urf_in_if and urf_out_if.
//
// Usage: drive one beat on sample for every microsecond tick, with operation set on
// the tick that should start a measurement. Every accepted beat yields exactly one beat
// on result, carrying the trigger pin level for that tick, busy, a one-beat done pulse,
// timed_out and the distance in sixteenths of a centimeter.
// A start while idle holds the trigger inactive for SETTLE_LOW_TICKS beats, drives it
// active for TRIGGER_HIGH_TICKS beats, then waits for the echo and times its width.
// Each accepted sample's result beat is registered and offered in the next cycle. Throughput
// is one beat per cycle while result takes its beats: the state update and the 13x15
// distance multiply both sit between the state registers and the result register.
// If result stalls, the result register holds its beat and sample.ready drops until it
// is taken; no beat is lost or repeated.
// The user must write configuration through wr_en/wr_index/wr_data only while idle; the
// block does not enforce it. A range write precomputes the echo timeout in the same edge.
// Reset (arst_n low) returns the block to idle, empties the result register and loads
// a range of 400 cm with both pins active high.
module ultrasonic_range_finder #(
	parameter int unsigned SETTLE_LOW_TICKS   = 5,
	parameter int unsigned TRIGGER_HIGH_TICKS = 10,
	parameter int unsigned TIMER_WIDTH        = 13
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [urf_pkg::CFG_INDEX_W-1:0]     wr_index,
	input  logic [urf_pkg::CFG_DATA_W-1:0]      wr_data,
	urf_in_if.sink                              sample,
	urf_out_if.source                           result
);

	localparam int unsigned LIM_PROD_W  = urf_pkg::RANGE_W + urf_pkg::LIMIT_MUL_W;
	localparam int unsigned DIST_PROD_W = TIMER_WIDTH + urf_pkg::DIST_MUL_W + 1;
	localparam logic [TIMER_WIDTH-1:0] CNT_MAX = {TIMER_WIDTH{1'b1}};

	// Configuration
	logic [urf_pkg::LIMIT_W-1:0] cfg_limit_q;
	logic                        echo_ah_q;
	logic                        trig_ah_q;

	logic [urf_pkg::RANGE_W-1:0] range_clamped;
	logic [LIM_PROD_W-1:0]       limit_prod;
	logic [urf_pkg::LIMIT_W-1:0] limit_new;

	// Sequencer state
	urf_pkg::phase_t        phase_q, phase_d;
	logic [TIMER_WIDTH-1:0] phase_ticks_q, phase_ticks_d;
	logic [TIMER_WIDTH-1:0] width_q, width_d;
	logic [TIMER_WIDTH-1:0] timeout_limit_q, timeout_limit_d;

	// Per-tick outputs
	logic                   fire;
	logic                   echo_on;
	logic                   trig_on;
	logic                   busy;
	logic                   done;
	logic                   tmo;
	logic                   dist_sel;
	logic [DIST_PROD_W-1:0] dist_prod;
	logic [urf_pkg::DIST_W-1:0] dist_val;

	// Result register
	logic                       res_valid_q;
	logic                       res_trig_q;
	logic                       res_busy_q;
	logic                       res_done_q;
	logic                       res_tmo_q;
	logic [urf_pkg::DIST_W-1:0] res_dist_q;

	function automatic logic [TIMER_WIDTH-1:0] sat_inc(input logic [TIMER_WIDTH-1:0] v);
		sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
	endfunction

	// ---------------------------------------------------------------- configuration
	assign range_clamped = (wr_data[urf_pkg::RANGE_W-1:0] >
		urf_pkg::RANGE_W'(urf_pkg::RANGE_CAP_CM)) ?
		urf_pkg::RANGE_W'(urf_pkg::RANGE_CAP_CM) : wr_data[urf_pkg::RANGE_W-1:0];
	assign limit_prod = LIM_PROD_W'(range_clamped) *
		LIM_PROD_W'(urf_pkg::LIMIT_MUL);
	assign limit_new = limit_prod[urf_pkg::LIMIT_SHIFT +: urf_pkg::LIMIT_W] +
		urf_pkg::LIMIT_W'(urf_pkg::LIMIT_OFFSET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_limit_q <= urf_pkg::LIMIT_W'(urf_pkg::LIMIT_RESET);
			echo_ah_q   <= 1'b1;
			trig_ah_q   <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				urf_pkg::REG_MAX_RANGE:   cfg_limit_q <= limit_new;
				urf_pkg::REG_ECHO_POL:    echo_ah_q   <= wr_data[0];
				urf_pkg::REG_TRIGGER_POL: trig_ah_q   <= wr_data[0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- handshake
	assign sample.ready = !res_valid_q || result.ready;
	assign fire         = sample.valid && sample.ready;
	assign echo_on      = (sample.echo_level == echo_ah_q);

	// Distance from the width counted so far; it is only selected on the falling tick.
	assign dist_prod = DIST_PROD_W'(width_q) * DIST_PROD_W'(urf_pkg::DIST_MUL) +
		DIST_PROD_W'(urf_pkg::DIST_ROUND);
	assign dist_val = dist_sel ? dist_prod[urf_pkg::DIST_SHIFT +: urf_pkg::DIST_W] : '0;

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= urf_pkg::PH_IDLE;
			phase_ticks_q   <= '0;
			width_q         <= '0;
			timeout_limit_q <= '0;
		end else if (fire) begin
			phase_q         <= phase_d;
			phase_ticks_q   <= phase_ticks_d;
			width_q         <= width_d;
			timeout_limit_q <= timeout_limit_d;
		end
	end

	always_comb begin
		urf_pkg::phase_t ph;
		ph              = phase_q;
		phase_ticks_d   = phase_ticks_q;
		width_d         = width_q;
		timeout_limit_d = timeout_limit_q;
		busy            = 1'b1;
		done            = 1'b0;
		tmo             = 1'b0;
		trig_on         = 1'b0;
		dist_sel        = 1'b0;

		// The start tick is handled as the first settle tick.
		if (phase_q != urf_pkg::PH_SETTLE && phase_q != urf_pkg::PH_PULSE &&
		    phase_q != urf_pkg::PH_WAIT_RISE && phase_q != urf_pkg::PH_MEASURE) begin
			ph = urf_pkg::PH_IDLE;
			if (sample.operation) begin
				ph              = urf_pkg::PH_SETTLE;
				timeout_limit_d = TIMER_WIDTH'(cfg_limit_q);
				phase_ticks_d   = '0;
				width_d         = '0;
			end else begin
				busy = 1'b0;
			end
		end

		unique case (ph)
			urf_pkg::PH_SETTLE: begin
				phase_ticks_d = sat_inc(phase_ticks_d);
				if (phase_ticks_d >= TIMER_WIDTH'(SETTLE_LOW_TICKS)) begin
					ph            = urf_pkg::PH_PULSE;
					phase_ticks_d = '0;
				end
			end
			urf_pkg::PH_PULSE: begin
				trig_on       = 1'b1;
				phase_ticks_d = sat_inc(phase_ticks_d);
				if (phase_ticks_d >= TIMER_WIDTH'(TRIGGER_HIGH_TICKS)) begin
					ph            = urf_pkg::PH_WAIT_RISE;
					phase_ticks_d = '0;
				end
			end
			urf_pkg::PH_WAIT_RISE: begin
				if (echo_on) begin
					ph            = urf_pkg::PH_MEASURE;
					phase_ticks_d = '0;
					width_d       = TIMER_WIDTH'(1);
				end else begin
					phase_ticks_d = sat_inc(phase_ticks_d);
					if (phase_ticks_d > timeout_limit_d) begin
						done = 1'b1;
						tmo  = 1'b1;
					end
				end
			end
			urf_pkg::PH_MEASURE: begin
				if (echo_on) begin
					width_d       = sat_inc(width_d);
					phase_ticks_d = sat_inc(phase_ticks_d);
					if (phase_ticks_d > timeout_limit_d) begin
						done = 1'b1;
						tmo  = 1'b1;
					end
				end else begin
					done     = 1'b1;
					dist_sel = 1'b1;
				end
			end
			default: ;
		endcase

		if (done) begin
			busy          = 1'b0;
			ph            = urf_pkg::PH_IDLE;
			phase_ticks_d = '0;
		end
		phase_d = ph;
	end

	// ---------------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_trig_q <= trig_on ? trig_ah_q : !trig_ah_q;
			res_busy_q <= busy;
			res_done_q <= done;
			res_tmo_q  <= tmo;
			res_dist_q <= dist_val;
		end
	end

	assign result.valid         = res_valid_q;
	assign result.trigger_level = res_trig_q;
	assign result.busy_res      = res_busy_q;
	assign result.done_res      = res_done_q;
	assign result.timed_out     = res_tmo_q;
	assign result.distance_q4   = res_dist_q;

`ifndef NO_ASSERTIONS
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.done_res && result.busy_res))
		else $error("done and busy reported on the same beat");

	a_timeout_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.timed_out) |-> (result.done_res && result.distance_q4 == '0))
		else $error("timeout without done or with a distance");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && phase_q == urf_pkg::PH_IDLE && !sample.operation) |=>
		phase_q == urf_pkg::PH_IDLE)
		else $error("sequence left idle without a start");

	a_wait_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == urf_pkg::PH_WAIT_RISE || phase_q == urf_pkg::PH_MEASURE) |->
		phase_ticks_q <= timeout_limit_q)
		else $error("echo wait ran past its timeout");
`endif

endmodule
